// ===== sv/ndi_pkg.sv =====
// shared types, codes and constants of the newton difference interpolator
// no dependencies
`default_nettype none

package ndi_pkg;

    // default number of sample slots
    localparam int MAX_POINTS_DEF = 16;

    // fraction bits of the Q16.16 format
    localparam int QFRAC = 16;

    // request action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_EVAL  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_X_ORIGIN    = 2'd1;
    localparam logic [1:0] REG_X_STEP      = 2'd2;
    localparam logic [1:0] REG_DIRECTION   = 2'd3;

    // magnitude bound for terms and the running sum
    localparam logic [63:0]        MAG_LIMIT = 64'h2000_0000_0000_0000;
    localparam logic signed [63:0] SUM_HI    = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] SUM_LO    = -64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] I32_HI    = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] I32_LO    = -64'sh0000_0000_8000_0000;
    localparam logic [31:0]        RES_MAX   = 32'h7fff_ffff;
    localparam logic [31:0]        RES_MIN   = 32'h8000_0000;

    // multiply / divide unit
    typedef enum logic {MD_MUL, MD_DIV} md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic done;
        logic hi_nz;
    } md_rsp_t;

endpackage

`default_nettype wire

// ===== sv/ndi_if.sv =====
// request, result and configuration channel interfaces
// no dependencies
`default_nettype none

interface ndi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] sample_value;
    logic [31:0] query_x;

    modport source (output valid, output action, output sample_value, output query_x,
                    input ready);
    modport sink   (input valid, input action, input sample_value, input query_x,
                    output ready);
endinterface

interface ndi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic [1:0]  status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

interface ndi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ndi_ram.sv =====
// simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module ndi_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/ndi_muldiv.sv =====
// bit-serial 64x64 multiplier and 64/64 restoring divider, one bit a cycle
// depends on ndi_pkg
`default_nettype none

module ndi_muldiv (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ndi_pkg::md_req_t req,
    input  wire logic [63:0]     opa,
    input  wire logic [63:0]     opb,
    output ndi_pkg::md_rsp_t     rsp,
    output logic [127:0]         result
);

    logic             busy_reg;
    logic             done_reg;
    ndi_pkg::md_op_t  op_reg;
    logic [5:0]       cnt_reg;
    logic [127:0]     acc_reg;
    logic [127:0]     mcand_reg;
    logic [63:0]      shift_reg;
    logic [63:0]      den_reg;
    logic [64:0]      rem_reg;

    logic [64:0]      rem_sh;
    logic [65:0]      trial;
    logic             ge;

    // one restoring division step
    always_comb
    begin
        rem_sh = {rem_reg[63:0], shift_reg[63]};
        trial  = {1'b0, rem_sh} - {2'b00, den_reg};
        ge     = ~trial[65];
    end

    // sequencing of the shared unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            op_reg    <= ndi_pkg::MD_MUL;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            mcand_reg <= '0;
            shift_reg <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            // done pulses after the last bit step
            done_reg <= busy_reg && !req.start && (cnt_reg == 6'd63);
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                op_reg    <= req.op;
                cnt_reg   <= '0;
                acc_reg   <= '0;
                mcand_reg <= {64'd0, opa};
                shift_reg <= (req.op == ndi_pkg::MD_MUL) ? opb : opa;
                den_reg   <= opb;
                rem_reg   <= '0;
            end
            else if (busy_reg)
            begin
                unique case (op_reg)
                    ndi_pkg::MD_MUL:
                    begin
                        if (shift_reg[0])
                        begin
                            acc_reg <= acc_reg + mcand_reg;
                        end
                        mcand_reg <= {mcand_reg[126:0], 1'b0};
                        shift_reg <= {1'b0, shift_reg[63:1]};
                    end
                    ndi_pkg::MD_DIV:
                    begin
                        rem_reg   <= ge ? trial[64:0] : rem_sh;
                        shift_reg <= {shift_reg[62:0], ge};
                    end
                endcase
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // quotient ends up in the shift register
    assign result    = (op_reg == ndi_pkg::MD_MUL) ? acc_reg : {64'd0, shift_reg};
    assign rsp.done  = done_reg;
    assign rsp.hi_nz = |result[127:64];

endmodule

`default_nettype wire

// ===== sv/newton_difference_interpolator.sv =====
// top level: sample and difference memories, sequencer, config registers
// depends on ndi_pkg, ndi_if, ndi_ram, ndi_muldiv
//
//  channel   dir   handshake      payload
//  in_req    in    valid/ready    action, sample_value, query_x
//  out_res   out   valid/ready    result_value, status
//  cfg_wr    in    valid/ready    index, data (always ready)
//
// load, clear and unused requests are handled in the idle state without leaving it
// evaluate time is set by the bit-serial multiply/divide unit, at most three operations
// per difference order, and by the one-entry-a-cycle passes over the difference memory
// too-few-sample evaluations go from idle straight to the emit state
// no clearing pass after reset
// a result waits in the output register while loads and clears are still taken
`default_nettype none

module newton_difference_interpolator #(
    parameter int MAX_POINTS = ndi_pkg::MAX_POINTS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ndi_in_if.sink     in_req,
    ndi_out_if.source  out_res,
    ndi_cfg_if.sink    cfg_wr
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NW = (CW > 5) ? CW : 5;
    localparam int DW = 34 + CW;

    typedef enum logic [3:0] {
        S_IDLE, S_PSTART, S_PWAIT, S_COPY, S_DIFF, S_FACT, S_TMUL, S_TDIV,
        S_CHECK, S_CMUL, S_NEXT, S_FINAL, S_EMIT
    } state_t;

    // configuration registers
    logic [4:0]  point_count_reg;
    logic [31:0] x_origin_reg;
    logic [30:0] x_step_reg;
    logic        direction_reg;

    // sequencer registers
    state_t            state_reg;
    logic [CW-1:0]     loaded_reg;
    logic [CW-1:0]     n_reg;
    logic              bw_reg;
    logic [30:0]       step_reg;
    logic [31:0]       qx_reg;
    logic [CW-1:0]     cnt_reg;
    logic [AW-1:0]     k_reg;
    logic [31:0]       prev_reg;
    logic [31:0]       dk_reg;
    logic              pneg_reg;
    logic [63:0]       p_reg;
    logic [63:0]       tmag_reg;
    logic              tneg_reg;
    logic              tsat_reg;
    logic              cneg_reg;
    logic              hard_reg;
    logic              hneg_reg;
    logic              dsat_reg;
    logic signed [63:0] sum_reg;
    logic [31:0]       res_pend_reg;
    logic [1:0]        st_pend_reg;
    logic              out_valid_reg;
    logic [31:0]       out_value_reg;
    logic [1:0]        out_status_reg;
    ndi_pkg::md_req_t  md_req_reg;
    logic [63:0]       opa_reg;
    logic [63:0]       opb_reg;

    // memory ports
    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic [AW-1:0]     s_raddr;
    logic [31:0]       s_rdata;
    logic              d_we;
    logic [AW-1:0]     d_waddr;
    logic [31:0]       d_wdata;
    logic [AW-1:0]     d_raddr;
    logic [31:0]       d_rdata;

    ndi_pkg::md_rsp_t  md_rsp;
    logic [127:0]      md_result;

    // combinational helpers
    logic              in_acc;
    logic [NW-1:0]     pc_w;
    logic [NW-1:0]     n_w;
    logic [CW:0]       diff_last;
    logic [CW:0]       bw_raddr;
    logic [CW:0]       bw_waddr;
    logic [CW-1:0]     anchor_idx;
    logic signed [32:0] dd;
    logic [31:0]       dsat_val;
    logic              dsat_now;
    logic [CW+30:0]    off_w;
    logic signed [DW-1:0] pdiff;
    logic [DW-1:0]     pmag;
    logic [63:0]       kq;
    logic [63:0]       f_w;
    logic [63:0]       fm_w;
    logic [32:0]       dk_abs;
    logic [63:0]       m_w;
    logic signed [63:0] newsum;

    // configuration writes
    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 5'd16;
            x_origin_reg    <= '0;
            x_step_reg      <= 31'd65536;
            direction_reg   <= 1'b0;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                ndi_pkg::REG_POINT_COUNT: point_count_reg <= cfg_wr.data[4:0];
                ndi_pkg::REG_X_ORIGIN:    x_origin_reg    <= cfg_wr.data;
                ndi_pkg::REG_X_STEP:      x_step_reg      <= cfg_wr.data[30:0];
                ndi_pkg::REG_DIRECTION:   direction_reg   <= cfg_wr.data[0];
            endcase
        end
    end

    // handshake and point count clamp
    assign in_acc = in_req.valid && in_req.ready;
    assign in_req.ready = (state_reg == S_IDLE);
    assign pc_w = NW'(point_count_reg);

    always_comb
    begin
        priority if (pc_w < NW'(2))
        begin
            n_w = NW'(2);
        end
        else if (pc_w > NW'(MAX_POINTS))
        begin
            n_w = NW'(MAX_POINTS);
        end
        else
        begin
            n_w = pc_w;
        end
    end

    // address arithmetic of the difference passes
    assign diff_last  = {1'b0, n_reg} - {{(CW+1-AW){1'b0}}, k_reg} + (CW+1)'(1);
    assign bw_raddr   = {1'b0, n_reg} - (CW+1)'(1) - {1'b0, cnt_reg};
    assign bw_waddr   = {1'b0, n_reg} + (CW+1)'(1) - {1'b0, cnt_reg};
    assign anchor_idx = bw_reg ? (n_reg - CW'(1)) : '0;

    // saturating difference of neighbouring entries
    always_comb
    begin
        if (bw_reg)
        begin
            dd = {prev_reg[31], prev_reg} - {d_rdata[31], d_rdata};
        end
        else
        begin
            dd = {d_rdata[31], d_rdata} - {prev_reg[31], prev_reg};
        end
        dsat_now = (dd[32] != dd[31]);
        if (dsat_now)
        begin
            dsat_val = dd[32] ? ndi_pkg::RES_MIN : ndi_pkg::RES_MAX;
        end
        else
        begin
            dsat_val = dd[31:0];
        end
    end

    // memory port control
    assign s_we    = in_acc && (in_req.action == ndi_pkg::ACT_LOAD)
                     && (loaded_reg < CW'(MAX_POINTS));
    assign s_waddr = loaded_reg[AW-1:0];
    assign s_raddr = cnt_reg[AW-1:0];

    always_comb
    begin
        d_we    = 1'b0;
        d_waddr = bw_reg ? bw_waddr[AW-1:0] : AW'(cnt_reg - CW'(2));
        d_wdata = dsat_val;
        d_raddr = bw_reg ? bw_raddr[AW-1:0] : cnt_reg[AW-1:0];
        if (state_reg == S_COPY)
        begin
            d_we    = (cnt_reg != '0);
            d_waddr = AW'(cnt_reg - CW'(1));
            d_wdata = s_rdata;
        end
        else if (state_reg == S_DIFF)
        begin
            d_we = (cnt_reg >= CW'(2));
        end
    end

    // query offset from the anchor sample
    always_comb
    begin
        off_w = (CW+31)'(n_reg - CW'(1)) * (CW+31)'(step_reg);
        pdiff = {{(DW-32){qx_reg[31]}}, qx_reg}
              - {{(DW-32){x_origin_reg[31]}}, x_origin_reg}
              - (bw_reg ? {{(DW-CW-31){1'b0}}, off_w} : DW'(0));
        pmag  = pdiff[DW-1] ? DW'(-pdiff) : DW'(pdiff);
    end

    // term factor and contribution operands
    always_comb
    begin
        kq     = 64'(k_reg - AW'(1)) << ndi_pkg::QFRAC;
        f_w    = bw_reg ? (p_reg + kq) : (p_reg - kq);
        fm_w   = f_w[63] ? (~f_w + 64'd1) : f_w;
        dk_abs = dk_reg[31] ? (33'd0 - {dk_reg[31], dk_reg}) : {1'b0, dk_reg};
        m_w    = {16'd0, md_result[63:16]};
        newsum = cneg_reg ? (sum_reg - $signed(m_w)) : (sum_reg + $signed(m_w));
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            loaded_reg     <= '0;
            n_reg          <= '0;
            bw_reg         <= 1'b0;
            step_reg       <= '0;
            qx_reg         <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            prev_reg       <= '0;
            dk_reg         <= '0;
            pneg_reg       <= 1'b0;
            p_reg          <= '0;
            tmag_reg       <= '0;
            tneg_reg       <= 1'b0;
            tsat_reg       <= 1'b0;
            cneg_reg       <= 1'b0;
            hard_reg       <= 1'b0;
            hneg_reg       <= 1'b0;
            dsat_reg       <= 1'b0;
            sum_reg        <= '0;
            res_pend_reg   <= '0;
            st_pend_reg    <= ndi_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ndi_pkg::ST_OK;
            md_req_reg     <= '{start: 1'b0, op: ndi_pkg::MD_MUL};
            opa_reg        <= '0;
            opb_reg        <= '0;
        end
        else
        begin
            // start is a one-cycle pulse; no state issues while it is high
            if (md_req_reg.start)
            begin
                md_req_reg.start <= 1'b0;
            end
            // result taken and nothing new handed over
            if (out_valid_reg && out_res.ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (in_req.action)
                            ndi_pkg::ACT_LOAD:
                            begin
                                if (s_we)
                                begin
                                    loaded_reg <= loaded_reg + CW'(1);
                                end
                            end
                            ndi_pkg::ACT_CLEAR:
                            begin
                                loaded_reg <= '0;
                            end
                            ndi_pkg::ACT_EVAL:
                            begin
                                n_reg    <= n_w[CW-1:0];
                                bw_reg   <= direction_reg;
                                step_reg <= (x_step_reg == '0) ? 31'd1 : x_step_reg;
                                qx_reg   <= in_req.query_x;
                                tmag_reg <= 64'd65536;
                                tneg_reg <= 1'b0;
                                tsat_reg <= 1'b0;
                                hard_reg <= 1'b0;
                                hneg_reg <= 1'b0;
                                dsat_reg <= 1'b0;
                                if (NW'(loaded_reg) < n_w)
                                begin
                                    res_pend_reg <= '0;
                                    st_pend_reg  <= ndi_pkg::ST_FEW;
                                    state_reg    <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_PSTART;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                // p = (x - anchor) * 2^16 / step, magnitude on the divider
                S_PSTART:
                begin
                    pneg_reg   <= pdiff[DW-1];
                    opa_reg    <= 64'(pmag) << ndi_pkg::QFRAC;
                    opb_reg    <= 64'(step_reg);
                    md_req_reg <= '{start: 1'b1, op: ndi_pkg::MD_DIV};
                    state_reg  <= S_PWAIT;
                end
                S_PWAIT:
                begin
                    if (md_rsp.done)
                    begin
                        p_reg     <= pneg_reg ? (64'd0 - md_result[63:0]) : md_result[63:0];
                        cnt_reg   <= '0;
                        state_reg <= S_COPY;
                    end
                end
                // copy samples into the difference memory, pick up the first sum
                S_COPY:
                begin
                    if ((cnt_reg != '0) && ((cnt_reg - CW'(1)) == anchor_idx))
                    begin
                        sum_reg <= 64'($signed(s_rdata));
                    end
                    if (cnt_reg == n_reg)
                    begin
                        k_reg     <= AW'(1);
                        cnt_reg   <= '0;
                        state_reg <= S_DIFF;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                // one difference order, entries read one a cycle
                S_DIFF:
                begin
                    if (cnt_reg != '0)
                    begin
                        prev_reg <= d_rdata;
                    end
                    if (cnt_reg >= CW'(2))
                    begin
                        if (dsat_now)
                        begin
                            dsat_reg <= 1'b1;
                        end
                        if (cnt_reg == CW'(2))
                        begin
                            dk_reg <= dsat_val;
                        end
                    end
                    if ({1'b0, cnt_reg} == diff_last)
                    begin
                        state_reg <= S_FACT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                // running product times the next factor, then divided by k
                S_FACT:
                begin
                    if (f_w == '0)
                    begin
                        tmag_reg  <= '0;
                        tsat_reg  <= 1'b0;
                        tneg_reg  <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        tneg_reg <= tneg_reg ^ f_w[63];
                        if (tsat_reg)
                        begin
                            state_reg <= S_CHECK;
                        end
                        else
                        begin
                            opa_reg    <= tmag_reg;
                            opb_reg    <= fm_w;
                            md_req_reg <= '{start: 1'b1, op: ndi_pkg::MD_MUL};
                            state_reg  <= S_TMUL;
                        end
                    end
                end
                S_TMUL:
                begin
                    if (md_rsp.done)
                    begin
                        if (md_rsp.hi_nz)
                        begin
                            tsat_reg  <= 1'b1;
                            state_reg <= S_CHECK;
                        end
                        else
                        begin
                            opa_reg    <= md_result[63:0];
                            opb_reg    <= 64'(k_reg) << ndi_pkg::QFRAC;
                            md_req_reg <= '{start: 1'b1, op: ndi_pkg::MD_DIV};
                            state_reg  <= S_TDIV;
                        end
                    end
                end
                S_TDIV:
                begin
                    if (md_rsp.done)
                    begin
                        if (md_result[63:0] > ndi_pkg::MAG_LIMIT)
                        begin
                            tsat_reg <= 1'b1;
                        end
                        else
                        begin
                            tmag_reg <= md_result[63:0];
                        end
                        state_reg <= S_CHECK;
                    end
                end
                // skip empty terms, stop on a saturated one
                S_CHECK:
                begin
                    if ((dk_reg == '0) || ((tmag_reg == '0) && !tsat_reg))
                    begin
                        state_reg <= S_NEXT;
                    end
                    else if (tsat_reg)
                    begin
                        hard_reg  <= 1'b1;
                        hneg_reg  <= tneg_reg ^ dk_reg[31];
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        cneg_reg   <= tneg_reg ^ dk_reg[31];
                        opa_reg    <= tmag_reg;
                        opb_reg    <= 64'(dk_abs);
                        md_req_reg <= '{start: 1'b1, op: ndi_pkg::MD_MUL};
                        state_reg  <= S_CMUL;
                    end
                end
                // add the contribution, watch the sum bound
                S_CMUL:
                begin
                    if (md_rsp.done)
                    begin
                        if (md_rsp.hi_nz)
                        begin
                            hard_reg  <= 1'b1;
                            hneg_reg  <= cneg_reg;
                            state_reg <= S_FINAL;
                        end
                        else if ((newsum > ndi_pkg::SUM_HI) || (newsum < ndi_pkg::SUM_LO))
                        begin
                            hard_reg  <= 1'b1;
                            hneg_reg  <= newsum[63];
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            sum_reg   <= newsum;
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_NEXT:
                begin
                    if (CW'(k_reg) == (n_reg - CW'(1)))
                    begin
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        cnt_reg   <= '0;
                        state_reg <= S_DIFF;
                    end
                end
                // final saturation and status
                S_FINAL:
                begin
                    priority if (hard_reg)
                    begin
                        res_pend_reg <= hneg_reg ? ndi_pkg::RES_MIN : ndi_pkg::RES_MAX;
                        st_pend_reg  <= ndi_pkg::ST_OVF;
                    end
                    else if (sum_reg > ndi_pkg::I32_HI)
                    begin
                        res_pend_reg <= ndi_pkg::RES_MAX;
                        st_pend_reg  <= ndi_pkg::ST_OVF;
                    end
                    else if (sum_reg < ndi_pkg::I32_LO)
                    begin
                        res_pend_reg <= ndi_pkg::RES_MIN;
                        st_pend_reg  <= ndi_pkg::ST_OVF;
                    end
                    else
                    begin
                        res_pend_reg <= sum_reg[31:0];
                        st_pend_reg  <= dsat_reg ? ndi_pkg::ST_OVF : ndi_pkg::ST_OK;
                    end
                    state_reg <= S_EMIT;
                end
                // hand over to the output register once it is free
                S_EMIT:
                begin
                    if (!out_valid_reg || out_res.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_pend_reg;
                        out_status_reg <= st_pend_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_res.valid        = out_valid_reg;
    assign out_res.result_value = out_value_reg;
    assign out_res.status       = out_status_reg;

    // sample store
    ndi_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (32)
    ) u_sample_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (in_req.sample_value),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // difference table; a pass writes two entries behind its read, so no forwarding
    ndi_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (32)
    ) u_diff_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // shared multiply / divide unit
    ndi_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req_reg),
        .opa    (opa_reg),
        .opb    (opb_reg),
        .rsp    (md_rsp),
        .result (md_result)
    );

endmodule

`default_nettype wire

// ===== sv/ndi_checker.sv =====
// port-level checks of the interpolator and their bind to the top level
// depends on ndi_pkg and newton_difference_interpolator
`default_nettype none

module ndi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  in_action,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_result,
    input wire logic [1:0]  out_status
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_result) && $stable(out_status))
        else $error("result payload changed while stalled");

    // only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == ndi_pkg::ST_OK) || (out_status == ndi_pkg::ST_FEW)
                      || (out_status == ndi_pkg::ST_OVF))
        else $error("undefined status code");

    // too few samples gives a zero value
    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ndi_pkg::ST_FEW) |-> (out_result == 32'd0))
        else $error("too-few result not zero");

    // a request that is not an evaluate raises no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action != ndi_pkg::ACT_EVAL) |=> !$rose(out_valid))
        else $error("result raised by a non-evaluate request");

endmodule

bind newton_difference_interpolator ndi_checker u_ndi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_ready   (in_req.ready),
    .in_action  (in_req.action),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_result (out_res.result_value),
    .out_status (out_res.status)
);

`default_nettype wire

// ===== sim/tb_newton_difference_interpolator.sv =====
// self-checking testbench of newton_difference_interpolator
// depends on ndi_pkg, ndi_if and the interpolator rtl
`timescale 1ns / 100ps
`default_nettype none

module tb_newton_difference_interpolator;

    localparam int NPTS        = 16;
    localparam int CYCLE_LIMIT = 20000000;

    logic clk;
    logic rst_n;

    ndi_in_if  in_req();
    ndi_out_if out_res();
    ndi_cfg_if cfg_wr();

    newton_difference_interpolator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req),
        .out_res (out_res),
        .cfg_wr  (cfg_wr)
    );

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } interp_result_t;

    // mirror of the block state and registers
    logic signed [31:0] mdl_samples [NPTS];
    int unsigned        mdl_loaded;
    logic [4:0]         mdl_point_count;
    logic signed [31:0] mdl_x_origin;
    logic [30:0]        mdl_x_step;
    logic               mdl_backward;

    interp_result_t expected_results [$];

    int  fail_count;
    int  results_checked;
    int  overflow_seen;
    int  few_seen;
    int  cycle_count;
    bit  idle_en;
    int  hold_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // time-out guard
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // saturating difference a - b, flag in bit 32
    function automatic logic [32:0] sat_sub(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d > 33'sd2147483647)
            return {1'b1, 32'h7fff_ffff};
        if (d < -33'sd2147483648)
            return {1'b1, 32'h8000_0000};
        return {1'b0, d[31:0]};
    endfunction

    // newton series evaluation at query qx
    task automatic newton_eval(input logic [31:0] qx, output interp_result_t r);
        int n;
        bit bw, dsat, hard, hneg, tneg, tsat, fneg, cneg;
        logic [63:0] tmag, fm, m, dm;
        logic signed [63:0] stp, anchor, p, sum, f, dk64;
        logic [127:0] prod;
        logic signed [31:0] work [NPTS];
        logic [32:0] sd;
        n = mdl_point_count;
        if (n < 2) n = 2;
        if (n > NPTS) n = NPTS;
        if (mdl_loaded < n)
        begin
            r.value = '0;
            r.status = ndi_pkg::ST_FEW;
            return;
        end
        bw = mdl_backward;
        dsat = 0; hard = 0; hneg = 0; tneg = 0; tsat = 0;
        tmag = 64'd65536;
        stp = (mdl_x_step == 0) ? 64'sd1 : $signed({33'd0, mdl_x_step});
        anchor = mdl_x_origin;
        if (bw) anchor = anchor + (n - 1) * stp;
        p = ($signed({{32{qx[31]}}, qx}) - anchor) * 64'sd65536 / stp;
        for (int j = 0; j < n; j++) work[j] = mdl_samples[j];
        sum = bw ? work[n-1] : work[0];
        for (int k = 1; k < n && !hard; k++)
        begin
            // next difference order
            if (bw)
            begin
                for (int j = n - 1; j >= k; j--)
                begin
                    sd = sat_sub(work[j], work[j-1]);
                    work[j] = sd[31:0];
                    dsat |= sd[32];
                end
                dk64 = work[n-1];
                f = p + (k - 1) * 64'sd65536;
            end
            else
            begin
                for (int j = 0; j + k < n; j++)
                begin
                    sd = sat_sub(work[j+1], work[j]);
                    work[j] = sd[31:0];
                    dsat |= sd[32];
                end
                dk64 = work[0];
                f = p - (k - 1) * 64'sd65536;
            end
            // running product term
            if (f == 0)
            begin
                tmag = 0; tsat = 0; tneg = 0;
            end
            else
            begin
                fneg = f < 0;
                fm = fneg ? -f : f;
                tneg = tneg ^ fneg;
                if (!tsat)
                begin
                    prod = {64'd0, tmag} * {64'd0, fm};
                    m = prod[63:0] / (64'd65536 * k);
                    if (|prod[127:64] || m > ndi_pkg::MAG_LIMIT) tsat = 1;
                    else tmag = m;
                end
            end
            if (dk64 == 0 || (tmag == 0 && !tsat))
                continue;
            cneg = tneg ^ (dk64 < 0);
            if (tsat)
            begin
                hard = 1; hneg = cneg;
                break;
            end
            dm = (dk64 < 0) ? -dk64 : dk64;
            prod = {64'd0, tmag} * {64'd0, dm};
            m = prod[63:0] / 64'd65536;
            if (|prod[127:64] || m > ndi_pkg::MAG_LIMIT)
            begin
                hard = 1; hneg = cneg;
                break;
            end
            sum = cneg ? sum - $signed(m) : sum + $signed(m);
            if (sum > ndi_pkg::SUM_HI || sum < ndi_pkg::SUM_LO)
            begin
                hard = 1; hneg = sum < 0;
                break;
            end
        end
        if (hard)
        begin
            r.value = hneg ? ndi_pkg::RES_MIN : ndi_pkg::RES_MAX;
            r.status = ndi_pkg::ST_OVF;
        end
        else if (sum > ndi_pkg::I32_HI)
        begin
            r.value = ndi_pkg::RES_MAX; r.status = ndi_pkg::ST_OVF;
        end
        else if (sum < ndi_pkg::I32_LO)
        begin
            r.value = ndi_pkg::RES_MIN; r.status = ndi_pkg::ST_OVF;
        end
        else
        begin
            r.value = sum[31:0];
            r.status = dsat ? ndi_pkg::ST_OVF : ndi_pkg::ST_OK;
        end
    endtask

    // update the mirror on every accepted request
    always @(posedge clk)
    begin
        interp_result_t r;
        if (rst_n && in_req.valid && in_req.ready)
        begin
            case (in_req.action)
                ndi_pkg::ACT_LOAD:
                    if (mdl_loaded < NPTS)
                    begin
                        mdl_samples[mdl_loaded] = in_req.sample_value;
                        mdl_loaded++;
                    end
                ndi_pkg::ACT_CLEAR: mdl_loaded = 0;
                ndi_pkg::ACT_EVAL:
                begin
                    newton_eval(in_req.query_x, r);
                    expected_results.push_back(r);
                end
                default: ;
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        interp_result_t e;
        if (rst_n && out_res.valid && out_res.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result value=%h status=%0d",
                       out_res.result_value, out_res.status);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                results_checked++;
                if (e.status == ndi_pkg::ST_OVF) overflow_seen++;
                if (e.status == ndi_pkg::ST_FEW) few_seen++;
                if (out_res.result_value !== e.value)
                begin
                    $error("result_value expected %h actual %h", e.value,
                           out_res.result_value);
                    fail_count++;
                end
                if (out_res.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, out_res.status);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls and the long hold-off
    initial
    begin
        int burst;
        burst = 0;
        out_res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_res.ready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                out_res.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(0, 6);
                out_res.ready <= 1'b0;
            end
            else
                out_res.ready <= 1'b1;
        end
    end

    // send one request, wait for acceptance, maybe idle afterwards
    task automatic send_req(input logic [1:0] act, input logic [31:0] yv,
                            input logic [31:0] qx);
        in_req.valid        <= 1'b1;
        in_req.action       <= act;
        in_req.sample_value <= yv;
        in_req.query_x      <= qx;
        do @(posedge clk); while (!in_req.ready);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // wait until the block has drained, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        in_req.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_wr.valid <= 1'b1;
        cfg_wr.index <= idx;
        cfg_wr.data  <= val;
        do @(posedge clk); while (!cfg_wr.ready);
        cfg_wr.valid <= 1'b0;
        case (idx)
            ndi_pkg::REG_POINT_COUNT: mdl_point_count = val[4:0];
            ndi_pkg::REG_X_ORIGIN:    mdl_x_origin = val;
            ndi_pkg::REG_X_STEP:      mdl_x_step = val[30:0];
            default:                  mdl_backward = val[0];
        endcase
    endtask

    task automatic set_config(input logic [31:0] pc, input logic [31:0] org,
                              input logic [31:0] stp, input logic dir);
        write_reg(ndi_pkg::REG_POINT_COUNT, pc);
        write_reg(ndi_pkg::REG_X_ORIGIN, org);
        write_reg(ndi_pkg::REG_X_STEP, stp);
        write_reg(ndi_pkg::REG_DIRECTION, {31'd0, dir});
    endtask

    function automatic logic [31:0] rand_sample(input bit full);
        if (full) return $urandom;
        return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endfunction

    // query near the sample grid, occasionally anywhere
    function automatic logic [31:0] rand_query(input int n);
        logic signed [63:0] q;
        logic signed [63:0] stp;
        if ($urandom_range(0, 9) == 0) return $urandom;
        stp = (mdl_x_step == 0) ? 1 : mdl_x_step;
        q = mdl_x_origin + ($signed($urandom_range(0, n + 1)) - 1) * stp;
        q = q + (($urandom & 32'h7fff_ffff) % stp);
        return q[31:0];
    endfunction

    task automatic load_set(input int cnt, input bit full);
        send_req(ndi_pkg::ACT_CLEAR, $urandom, $urandom);
        repeat (cnt) send_req(ndi_pkg::ACT_LOAD, rand_sample(full), $urandom);
    endtask

    // reset values, forward series over sixteen samples, store full
    task automatic test_reset_defaults();
        for (int i = 0; i < 17; i++)
            send_req(ndi_pkg::ACT_LOAD, (i * i) <<< 16, $urandom);
        send_req(ndi_pkg::ACT_EVAL, $urandom, 32'h0002_8000);
    endtask

    // too few samples, clamped point counts, zero step, unused action
    task automatic test_odd_settings();
        set_config(3, 32'h8000_0000, 0, 1'b0);
        send_req(ndi_pkg::ACT_CLEAR, 0, 0);
        send_req(ndi_pkg::ACT_LOAD, 32'h7fff_ffff, 0);
        send_req(ndi_pkg::ACT_EVAL, 0, 32'h8000_0000);
        send_req(2'd3, $urandom, $urandom);
        send_req(ndi_pkg::ACT_LOAD, 32'h8000_0000, 0);
        send_req(ndi_pkg::ACT_LOAD, 32'h7fff_ffff, 0);
        send_req(ndi_pkg::ACT_EVAL, 0, 32'h7fff_ffff);
        write_reg(ndi_pkg::REG_POINT_COUNT, 0);
        send_req(ndi_pkg::ACT_EVAL, 0, 32'h8000_0002);
        write_reg(ndi_pkg::REG_POINT_COUNT, 31);
        send_req(ndi_pkg::ACT_EVAL, 0, 32'h8000_0001);
    endtask

    // backward series and saturation at the extremes
    task automatic test_backward_extremes();
        set_config(4, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        send_req(ndi_pkg::ACT_CLEAR, 0, 0);
        send_req(ndi_pkg::ACT_LOAD, 32'h8000_0000, 0);
        send_req(ndi_pkg::ACT_LOAD, 32'h7fff_ffff, 0);
        send_req(ndi_pkg::ACT_LOAD, 32'h8000_0000, 0);
        send_req(ndi_pkg::ACT_LOAD, 32'h0001_0000, 0);
        send_req(ndi_pkg::ACT_EVAL, 0, 32'h8000_0000);
        send_req(ndi_pkg::ACT_EVAL, 0, 32'h7fff_ffff);
        set_config(2, 0, 32'h0001_0000, 1'b1);
        send_req(ndi_pkg::ACT_EVAL, 0, 32'h0001_0000);
    endtask

    // receiver held off while evaluations keep coming
    task automatic test_output_backpressure();
        set_config(2, 0, 32'h0001_0000, 1'b0);
        load_set(2, 0);
        hold_cycles = 800;
        repeat (12) send_req(ndi_pkg::ACT_EVAL, 0, rand_query(2));
    endtask

    // random phases of configuration, sample sets and queries
    task automatic test_random(input int items);
        int sent, n, cnt;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(0, 7) == 0) ? NPTS : $urandom_range(2, 6);
            set_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : n,
                       ($urandom_range(0, 1) == 0) ? $urandom : 32'(($urandom_range(0, 64)
                       - 32) <<< 16),
                       ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 32'h0004_0000),
                       $urandom_range(0, 1));
            repeat ($urandom_range(1, 3))
            begin
                cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n;
                load_set(cnt, $urandom_range(0, 3) == 0);
                sent += cnt + 1;
                repeat ($urandom_range(2, 8))
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_req($urandom_range(0, 3), $urandom, $urandom);
                    else
                        send_req(ndi_pkg::ACT_EVAL, $urandom, rand_query(n));
                    sent++;
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        fail_count = 0; results_checked = 0; overflow_seen = 0; few_seen = 0;
        hold_cycles = 0;
        idle_en = 1;
        mdl_loaded = 0;
        mdl_point_count = 16; mdl_x_origin = 0; mdl_x_step = 31'h0001_0000; mdl_backward = 0;
        for (int i = 0; i < NPTS; i++) mdl_samples[i] = 0;
        in_req.valid = 1'b0; in_req.action = ndi_pkg::ACT_LOAD;
        in_req.sample_value = '0; in_req.query_x = '0;
        cfg_wr.valid = 1'b0; cfg_wr.index = ndi_pkg::REG_POINT_COUNT; cfg_wr.data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_odd_settings();
        test_backward_extremes();
        test_output_backpressure();
        test_random(520);
        idle_en = 0;
        test_random(110);

        in_req.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("checked %0d results (%0d overflow, %0d too few) over forward and",
                 results_checked, overflow_seen, few_seen);
        $display("backward series, clamped counts, zero step and output back-pressure");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
